// ===== src/bffa_pkg.sv =====
// Package for the bitmap first-fit block allocator.
// Holds field widths, block mark codes, opcodes and the compare flag struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

  localparam int NUM_BLOCKS_DEF  = 32;
  localparam int BLOCK_BYTES_DEF = 4096;

  localparam int SIZE_W   = 24;
  localparam int ADDR_W   = 17;
  localparam int OFFSET_W = 17;
  localparam int MARK_W   = 2;

  localparam logic [MARK_W-1:0] MARK_FREE  = 2'd0;
  localparam logic [MARK_W-1:0] MARK_START = 2'd1;
  localparam logic [MARK_W-1:0] MARK_CONT  = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic ge;  // sum >= reference
    logic gt;  // sum >  reference
  } cmp_t;

endpackage

`default_nettype wire

// ===== src/bitmap_first_fit_block_allocator.sv =====
// Top level of the bitmap first-fit block allocator: sequencer, mark RAM and
// shared step unit. Depends on bffa_pkg, bffa_ram and bffa_step_unit.
//
// The pool of NUM_BLOCKS blocks of BLOCK_BYTES bytes is tracked by a mark RAM
// that a sequencer walks one block per cycle, with a single adder/comparator
// doing the byte arithmetic. After reset a clearing pass frees every block;
// in_stall is high meanwhile. An allocate is taken in the idle state, scans
// block by block up to the end of the first fitting run, marks each block of
// the granted run and then presents the result. A free searches the block
// indices to locate its address, clears each block of the run that starts
// there and then presents the result. One item is in work at a time; the
// result sits in an output register, so the next item is taken while a
// result waits.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_fit_block_allocator #(
  parameter int NUM_BLOCKS  = bffa_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = bffa_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [bffa_pkg::SIZE_W-1:0]   in_size_bytes,
  input  wire logic [bffa_pkg::ADDR_W-1:0]   in_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_ok,
  output logic [bffa_pkg::OFFSET_W-1:0]      out_offset
);

  localparam int IW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int RW   = $clog2(NUM_BLOCKS + 1);
  localparam int PW   = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
  localparam int UW   = (PW > bffa_pkg::SIZE_W) ? PW : bffa_pkg::SIZE_W;
  localparam logic [IW-1:0] LAST = IW'(NUM_BLOCKS - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_MARK  = 7'b0001000,
    ST_FIND  = 7'b0010000,
    ST_FWALK = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [UW-1:0] acc_r, acc_nxt;
  logic [RW-1:0] run_r, run_nxt;
  logic [IW-1:0] first_r, first_nxt;
  logic [IW-1:0] end_r, end_nxt;
  logic          head_r, head_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic          op_r;
  logic [bffa_pkg::SIZE_W-1:0] size_r;
  logic [bffa_pkg::ADDR_W-1:0] addr_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r;
  logic [bffa_pkg::OFFSET_W-1:0] out_offset_r;

  logic          accept;
  logic          load_out;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [bffa_pkg::MARK_W-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [bffa_pkg::MARK_W-1:0] mark;
  logic [UW-1:0] step_ref;
  logic [UW-1:0] step_sum;
  bffa_pkg::cmp_t step_cmp;
  logic [UW-1:0] off_prod;
  logic          mark_free;
  logic [IW-1:0] idx_inc;

  bffa_ram #(
    .WIDTH (bffa_pkg::MARK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (mark)
  );

  bffa_step_unit #(
    .W    (UW),
    .STEP (BLOCK_BYTES)
  ) u_step (
    .acc     (acc_r),
    .ref_val (step_ref),
    .sum     (step_sum),
    .cmp     (step_cmp)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign load_out  = (state_r == ST_RESP) && (!out_valid_r || !out_stall);
  assign mark_free = (mark == bffa_pkg::MARK_FREE);
  assign idx_inc   = (idx_r == LAST) ? '0 : IW'(idx_r + 1'b1);
  assign step_ref  = (state_r == ST_SCAN) ? UW'(size_r) : UW'(addr_r);
  assign off_prod  = UW'(first_r) * UW'(BLOCK_BYTES);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    run_nxt    = run_r;
    first_nxt  = first_r;
    end_nxt    = end_r;
    head_nxt   = head_r;
    res_ok_nxt = res_ok_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = bffa_pkg::MARK_FREE;
    ram_raddr  = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_IDLE: begin
        // Block 0 is read now so that its mark is ready on entry to the scan.
        ram_raddr = '0;
        idx_nxt   = '0;
        acc_nxt   = '0;
        run_nxt   = '0;
        head_nxt  = 1'b1;
        if (accept) begin
          if (in_op == bffa_pkg::OP_FREE) begin
            state_nxt = ST_FIND;
          end else if (in_size_bytes == '0) begin
            res_ok_nxt = 1'b0;
            state_nxt  = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // The mark of block idx_r is on the RAM output; the next one is read.
        ram_raddr = idx_inc;
        run_nxt   = mark_free ? RW'(run_r + 1'b1) : '0;
        acc_nxt   = mark_free ? step_sum : '0;
        if (mark_free && step_cmp.ge) begin
          first_nxt = IW'(32'(idx_r) + 32'd1 - 32'(run_nxt));
          end_nxt   = idx_r;
          idx_nxt   = first_nxt;
          state_nxt = ST_MARK;
        end else if (idx_r == LAST) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ST_RESP;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = (idx_r == first_r) ? bffa_pkg::MARK_START : bffa_pkg::MARK_CONT;
        if (idx_r == end_r) begin
          res_ok_nxt = 1'b1;
          state_nxt  = ST_RESP;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_FIND: begin
        // Block idx_r holds the address when idx_r*B <= address < (idx_r+1)*B.
        ram_raddr = idx_r;
        if (step_cmp.gt) begin
          state_nxt = ST_FWALK;
        end else if (idx_r == LAST) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ST_RESP;
        end else begin
          acc_nxt = step_sum;
          idx_nxt = idx_inc;
        end
      end
      ST_FWALK: begin
        ram_raddr = idx_inc;
        if (head_r) begin
          if (mark == bffa_pkg::MARK_START) begin
            ram_we     = 1'b1;
            res_ok_nxt = 1'b1;
            head_nxt   = 1'b0;
            if (idx_r == LAST) begin
              state_nxt = ST_RESP;
            end else begin
              idx_nxt = idx_inc;
            end
          end else begin
            res_ok_nxt = 1'b0;
            state_nxt  = ST_RESP;
          end
        end else if (mark == bffa_pkg::MARK_CONT) begin
          ram_we = 1'b1;
          if (idx_r == LAST) begin
            state_nxt = ST_RESP;
          end else begin
            idx_nxt = idx_inc;
          end
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    run_r    <= run_nxt;
    first_r  <= first_nxt;
    end_r    <= end_nxt;
    head_r   <= head_nxt;
    res_ok_r <= res_ok_nxt;
    if (accept) begin
      op_r   <= in_op;
      size_r <= in_size_bytes;
      addr_r <= in_address;
    end
    if (load_out) begin
      out_ok_r     <= res_ok_r;
      out_offset_r <= (res_ok_r && (op_r == bffa_pkg::OP_ALLOC)) ?
                      off_prod[bffa_pkg::OFFSET_W-1:0] : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_offset = out_offset_r;

endmodule

`default_nettype wire

// ===== src/bffa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bffa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/bffa_step_unit.sv =====
// Shared step unit: adds one block size to an accumulator and compares the sum
// against a reference. Depends on bffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bffa_step_unit #(
  parameter int W    = 27,
  parameter int STEP = 4096
) (
  input  wire logic [W-1:0]    acc,
  input  wire logic [W-1:0]    ref_val,
  output logic      [W-1:0]    sum,
  output bffa_pkg::cmp_t       cmp
);

  assign sum    = acc + W'(STEP);
  assign cmp.ge = (sum >= ref_val);
  assign cmp.gt = (sum > ref_val);

endmodule

`default_nettype wire

// ===== src/bffa_checker.sv =====
// Port-level checker for the bitmap first-fit block allocator, bound to the top
// level. Depends on bffa_pkg and bitmap_first_fit_block_allocator.
`timescale 1ns / 1ps
`default_nettype none

module bffa_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_ok,
  input wire logic [bffa_pkg::OFFSET_W-1:0] out_offset
);

  // The clearing pass holds off input items straight after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during the clearing pass");

  // Only one item is in work, so an accepted item makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in work");

  // A failed or ignored item always reports a zero offset.
  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_offset == '0))
    else $error("failed result carries a non-zero offset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_ok) && $stable(out_offset)))
    else $error("stalled result changed");

endmodule

bind bitmap_first_fit_block_allocator bffa_checker u_bffa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_ok     (out_ok),
  .out_offset (out_offset)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for bitmap_first_fit_block_allocator: directed and random
// allocate/free items, checked against a block-map model kept in a scoreboard class.
// Depends on bffa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;

  localparam int BLOCKS     = bffa_pkg::NUM_BLOCKS_DEF;
  localparam int BLOCK_SZ   = bffa_pkg::BLOCK_BYTES_DEF;
  localparam int SIZE_W     = bffa_pkg::SIZE_W;
  localparam int ADDR_W     = bffa_pkg::ADDR_W;
  localparam int OFFSET_W   = bffa_pkg::OFFSET_W;
  localparam int MARK_W     = bffa_pkg::MARK_W;
  localparam int RAND_ITEMS = 1750;
  localparam int LONG_HOLD  = 300;
  localparam int MAX_CYCLES = 1000000;

  typedef struct packed {
    logic                ok;
    logic [OFFSET_W-1:0] offset;
  } grant_t;

  // Block map model and queue of outstanding grants.
  class alloc_scoreboard;
    logic [MARK_W-1:0] marks [BLOCKS];
    grant_t            pending_grants [$];
    int                fails;

    function new();
      foreach (marks[i]) marks[i] = bffa_pkg::MARK_FREE;
      fails = 0;
    endfunction

    function grant_t predict_grant(logic op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
      grant_t      g;
      int unsigned needed;
      int unsigned run;
      int unsigned idx;
      int unsigned first;
      g = '0;
      if (op == bffa_pkg::OP_ALLOC) begin
        if (sz == 0) return g;
        needed = (int'(sz) + BLOCK_SZ - 1) / BLOCK_SZ;
        if (needed > BLOCKS) return g;
        run = 0;
        for (int i = 0; i < BLOCKS; i++) begin
          run = (marks[i] == bffa_pkg::MARK_FREE) ? run + 1 : 0;
          if (run == needed) begin
            first = i + 1 - needed;
            marks[first] = bffa_pkg::MARK_START;
            for (int k = first + 1; k <= i; k++) marks[k] = bffa_pkg::MARK_CONT;
            g.ok     = 1'b1;
            g.offset = OFFSET_W'(first * BLOCK_SZ);
            return g;
          end
        end
        return g;
      end
      idx = int'(ad) / BLOCK_SZ;
      if (idx >= BLOCKS || marks[idx] != bffa_pkg::MARK_START) return g;
      marks[idx] = bffa_pkg::MARK_FREE;
      idx++;
      // The walk stops at a free block, another run start, or the end of the pool.
      while (idx < BLOCKS && marks[idx] == bffa_pkg::MARK_CONT) begin
        marks[idx] = bffa_pkg::MARK_FREE;
        idx++;
      end
      g.ok = 1'b1;
      return g;
    endfunction

    function void note_request(logic op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
      pending_grants.push_back(predict_grant(op, sz, ad));
    endfunction

    function void check_grant(logic ok, logic [OFFSET_W-1:0] offset);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $error("result with no request waiting: ok=%0b offset=%0h", ok, offset);
        fails++;
        return;
      end
      g = pending_grants.pop_front();
      if (ok !== g.ok) begin
        $error("ok: expected %0b, actual %0b", g.ok, ok);
        fails++;
      end
      if (offset !== g.offset) begin
        $error("offset: expected %0h, actual %0h", g.offset, offset);
        fails++;
      end
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    function int pick_run_start();
      int starts [$];
      foreach (marks[i]) if (marks[i] == bffa_pkg::MARK_START) starts.push_back(i);
      if (starts.size() == 0) return -1;
      return starts[$urandom_range(0, starts.size() - 1)];
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_op;
  logic [SIZE_W-1:0]   in_size_bytes;
  logic [ADDR_W-1:0]   in_address;
  logic                out_valid;
  logic                out_stall;
  logic                out_ok;
  logic [OFFSET_W-1:0] out_offset;

  alloc_scoreboard sb;
  bit              idle_on;
  bit              long_hold;
  bit              hold_done = 1'b0;
  int              cycles = 0;

  bitmap_first_fit_block_allocator u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_size_bytes (in_size_bytes),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_offset    (out_offset)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_grant(out_ok, out_offset);
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic op, input logic [SIZE_W-1:0] sz,
                           input logic [ADDR_W-1:0] ad);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_size_bytes <= sz;
    in_address    <= ad;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, sz, ad);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random_item();
    int                r;
    int                nblk;
    int                idx;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ad;
    r  = $urandom_range(0, 99);
    sz = SIZE_W'($urandom());
    ad = ADDR_W'($urandom());
    idx = (r >= 50 && r < 88) ? sb.pick_run_start() : 0;
    if (r < 45 || (r >= 50 && r < 88 && idx < 0)) begin
      nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, BLOCKS) : $urandom_range(1, 4);
      sz   = SIZE_W'((nblk - 1) * BLOCK_SZ + $urandom_range(1, BLOCK_SZ));
      send_item(bffa_pkg::OP_ALLOC, sz, ad);
    end else if (r < 50) begin
      if ($urandom_range(0, 3) == 0) sz = '0;
      send_item(bffa_pkg::OP_ALLOC, sz, ad);
    end else if (r < 88) begin
      // Any byte inside the start block names the run.
      send_item(bffa_pkg::OP_FREE, sz,
                ADDR_W'(idx * BLOCK_SZ + $urandom_range(0, BLOCK_SZ - 1)));
    end else begin
      send_item(bffa_pkg::OP_FREE, sz, ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)));
    end
  endtask

  initial begin
    sb            = new();
    idle_on       = 1'b1;
    long_hold     = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= bffa_pkg::OP_ALLOC;
    in_size_bytes <= '0;
    in_address    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Whole pool in one run, then a request against a full map.
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(BLOCKS * BLOCK_SZ), '0);
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(1), '1);
    send_item(bffa_pkg::OP_FREE, '1, '1);
    send_item(bffa_pkg::OP_FREE, '0, ADDR_W'(BLOCK_SZ - 1));
    send_item(bffa_pkg::OP_FREE, '1, '0);
    send_item(bffa_pkg::OP_ALLOC, '0, '1);
    send_item(bffa_pkg::OP_ALLOC, '1, '0);
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(BLOCKS * BLOCK_SZ + 1), '0);
    // Adjacent runs of assorted sizes; the last one ends on the final block.
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(1), '0);
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(BLOCK_SZ), '0);
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(BLOCK_SZ + 1), '0);
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'((BLOCKS - 4) * BLOCK_SZ), '0);
    send_item(bffa_pkg::OP_FREE, '0, '1);
    send_item(bffa_pkg::OP_FREE, '0, ADDR_W'(4 * BLOCK_SZ + 123));
    send_item(bffa_pkg::OP_FREE, '0, ADDR_W'(BLOCK_SZ));
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(2 * BLOCK_SZ), '0);
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(BLOCK_SZ), '0);
    send_item(bffa_pkg::OP_FREE, '0, '0);
    send_item(bffa_pkg::OP_FREE, '0, ADDR_W'(2 * BLOCK_SZ));
    send_item(bffa_pkg::OP_FREE, '0, ADDR_W'(3 * BLOCK_SZ));
    send_item(bffa_pkg::OP_ALLOC, SIZE_W'(3 * BLOCK_SZ - 1), '0);
    wait_drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == 900) wait_drain();
      idle_on = !((i >= 800 && i < 950) || i >= RAND_ITEMS - 250);
      send_random_item();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/bffa_pkg.sv
src/bffa_ram.sv
src/bffa_step_unit.sv
src/bitmap_first_fit_block_allocator.sv
src/bffa_checker.sv
tb/tb.sv
